>>> hw/rtl/hlcd_pkg.sv
// ----------------------------------------------------------------------------
// hlcd_pkg
// Shared types and constants of the sync/length/checksum frame parser.
// ----------------------------------------------------------------------------
package hlcd_pkg;

  localparam int BUFFER_DEPTH_DEF = 64;
  localparam int CMD_DEPTH_DEF    = 2;

  localparam logic [7:0] SYNC_A   = 8'hFE;
  localparam logic [7:0] SYNC_B   = 8'hEF;
  localparam logic [7:0] SUM_GOOD = 8'hFF;

  localparam logic [6:0] BUF_LEN_RESET = 7'd64;
  localparam logic [6:0] BUF_LEN_MIN   = 7'd4;

  // result status codes
  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_IGNORED  = 3'd1;
  localparam logic [2:0] ST_GOOD     = 3'd2;
  localparam logic [2:0] ST_CSUM_ERR = 3'd3;
  localparam logic [2:0] ST_OVERLEN  = 3'd4;

  // request types
  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // command from the parser to the result sequencer
  typedef struct packed {
    logic       is_frame;  // emit a whole good frame
    logic [2:0] status;    // status of a single result
    logic [6:0] total;     // frame length in bytes, 4..64
  } cmd_t;

endpackage

>>> hw/rtl/hlcd_ram.sv
// ----------------------------------------------------------------------------
// hlcd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hlcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/hlcd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// hlcd_cmd_fifo
// Short command queue between the byte parser and the result sequencer.
// ----------------------------------------------------------------------------
module hlcd_cmd_fifo
  import hlcd_pkg::*;
#(
  parameter int DEPTH = CMD_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  input  logic rd_en,
  output cmd_t rd_cmd,
  output logic q_full,
  output logic q_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign q_full  = (count == CW'(DEPTH));
  assign q_empty = (count == '0);
  assign rd_cmd  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/hlcd_front.sv
// ----------------------------------------------------------------------------
// hlcd_front
// Byte parser: sync hunt, length check, running checksum, frame store writes.
// Issues one command per accepted word.
// ----------------------------------------------------------------------------
module hlcd_front
  import hlcd_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic                            req_type,
  input  logic [7:0]                      rx_byte,
  input  logic [6:0]                      buffer_length,
  input  logic                            frame_done,
  output cmd_t                            cmd,
  output logic                            busy,
  output logic                            ram_we,
  output logic [$clog2(BUFFER_DEPTH)-1:0] ram_waddr,
  output logic [7:0]                      ram_wdata
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam logic [6:0] DEPTH7 = 7'(BUFFER_DEPTH);

  logic       sync_first_seen, sync_first_seen_next;
  logic       in_frame, in_frame_next;
  logic       holding, holding_next;
  logic [6:0] frame_index, frame_index_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] running_sum, running_sum_next;

  logic [6:0] eff_len;
  logic [7:0] sum_add;
  logic [7:0] len_sel;
  logic [8:0] total9;
  logic [6:0] idx_inc;

  always_comb begin
    if (buffer_length < BUF_LEN_MIN) begin
      eff_len = BUF_LEN_MIN;
    end else if (buffer_length > DEPTH7) begin
      eff_len = DEPTH7;
    end else begin
      eff_len = buffer_length;
    end
  end

  assign sum_add   = running_sum + rx_byte;
  assign len_sel   = (frame_index == 7'd2) ? rx_byte : frame_length;
  assign total9    = {1'b0, len_sel} + 9'd4;
  assign idx_inc   = frame_index + 7'd1;
  assign ram_waddr = frame_index[AW-1:0];
  assign ram_wdata = rx_byte;

  always_comb begin
    sync_first_seen_next = sync_first_seen;
    in_frame_next        = in_frame;
    holding_next         = holding;
    frame_index_next     = frame_index;
    frame_length_next    = frame_length;
    running_sum_next     = running_sum;
    ram_we               = 1'b0;
    cmd.is_frame         = 1'b0;
    cmd.status           = ST_ACCEPTED;
    cmd.total            = total9[6:0];

    if (req_type == REQ_RELEASE) begin
      holding_next = 1'b0;
    end else if (holding) begin
      cmd.status = ST_IGNORED;
    end else if (rx_byte == SYNC_B && sync_first_seen) begin
      // restart the frame, also in the middle of one
      sync_first_seen_next = 1'b0;
      in_frame_next        = 1'b1;
      frame_index_next     = 7'd2;
      frame_length_next    = '0;
      running_sum_next     = SYNC_A + SYNC_B;
    end else begin
      sync_first_seen_next = (rx_byte == SYNC_A);
      if (in_frame) begin
        if (frame_index >= DEPTH7) begin
          in_frame_next = 1'b0;
          cmd.status    = ST_OVERLEN;
        end else begin
          ram_we           = 1'b1;
          running_sum_next = sum_add;
          frame_length_next = len_sel;
          if (frame_index == 7'd2 && total9 > {2'b00, eff_len}) begin
            in_frame_next = 1'b0;
            cmd.status    = ST_OVERLEN;
          end else if ({2'b00, idx_inc} == total9) begin
            in_frame_next        = 1'b0;
            sync_first_seen_next = 1'b0;
            frame_index_next     = '0;
            if (sum_add == SUM_GOOD) begin
              holding_next = 1'b1;
              cmd.is_frame = 1'b1;
              cmd.status   = ST_GOOD;
            end else begin
              cmd.status = ST_CSUM_ERR;
            end
          end else begin
            frame_index_next = idx_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first_seen <= 1'b0;
      in_frame        <= 1'b0;
      holding         <= 1'b0;
      frame_index     <= '0;
      frame_length    <= '0;
      running_sum     <= '0;
      busy            <= 1'b0;
    end else begin
      if (accept) begin
        sync_first_seen <= sync_first_seen_next;
        in_frame        <= in_frame_next;
        holding         <= holding_next;
        frame_index     <= frame_index_next;
        frame_length    <= frame_length_next;
        running_sum     <= running_sum_next;
      end
      // block new words while a frame is still read out of the store
      if (accept && cmd.is_frame) begin
        busy <= 1'b1;
      end else if (frame_done) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/hlcd_back.sv
// ----------------------------------------------------------------------------
// hlcd_back
// Result sequencer: turns commands into result words, reading good frames
// out of the frame store, with a read stage and an output register.
// ----------------------------------------------------------------------------
module hlcd_back
  import hlcd_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  cmd_t                            head,
  input  logic                            q_empty,
  output logic                            q_pop,
  output logic                            frame_done,
  output logic                            ram_re,
  output logic [$clog2(BUFFER_DEPTH)-1:0] ram_raddr,
  input  logic [7:0]                      ram_rdata,
  input  logic                            pop,
  output logic                            empty,
  output logic [2:0]                      status,
  output logic [7:0]                      data_byte,
  output logic [5:0]                      byte_index,
  output logic                            last
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic [6:0] k;
  logic       issue;
  logic       last_item;

  logic       s1_valid;
  logic       s1_frame;
  logic [2:0] s1_status;
  logic [5:0] s1_k;
  logic       s1_last;
  logic       s1_adv;

  logic       out_valid;
  logic [7:0] s1_data;

  assign s1_adv     = s1_valid && (!out_valid || pop);
  assign issue      = !q_empty && (!s1_valid || s1_adv);
  assign last_item  = !head.is_frame || ((k + 7'd1) == head.total);
  assign q_pop      = issue && last_item;
  assign frame_done = q_pop && head.is_frame;
  assign ram_re     = issue && head.is_frame;
  assign ram_raddr  = k[AW-1:0];
  assign empty      = !out_valid;

  always_comb begin
    if (!s1_frame) begin
      s1_data = '0;
    end else if (s1_k == 6'd0) begin
      s1_data = SYNC_A;
    end else if (s1_k == 6'd1) begin
      s1_data = SYNC_B;
    end else begin
      s1_data = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_frame  <= head.is_frame;
      s1_status <= head.status;
      s1_k      <= head.is_frame ? k[5:0] : 6'd0;
      s1_last   <= last_item;
    end
    if (s1_adv) begin
      status     <= s1_status;
      data_byte  <= s1_data;
      byte_index <= s1_k;
      last       <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        k <= '0;
      end else if (issue) begin
        k <= k + 7'd1;
      end
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_ram_read_for_frame : assert property (@(posedge clk) disable iff (rst)
    ram_re |-> (head.is_frame && !q_empty))
    else $error("frame store read without a frame command");

  a_single_pops : assert property (@(posedge clk) disable iff (rst)
    (issue && !head.is_frame) |-> q_pop)
    else $error("single result did not retire its command");

  a_non_frame_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_GOOD) |-> (data_byte == 8'd0 && byte_index == 6'd0 && last))
    else $error("non-frame result carries data");

  a_stage_held : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> s1_valid)
    else $error("read stage dropped a word");

endmodule

>>> hw/rtl/header_length_checksum_deframer_top.sv
// ----------------------------------------------------------------------------
// header_length_checksum_deframer_top
// Serial frame parser: sync pair FE EF, length byte, additive checksum.
//
//   channel  | handshake         | payload
//   ---------+-------------------+---------------------------------------
//   input    | push / full       | req_type, rx_byte
//   result   | empty / pop       | status, data_byte, byte_index, last
//   config   | APB psel/penable  | buffer_length at byte offset 0
//
// One input word per cycle while the command queue has room; each word
// yields one command. A good frame of N bytes comes out as N result words,
// one per cycle while results are popped, one frame store read per word.
// New input words wait while a good frame is still being read out.
// Synchronous active-high reset clears all control state; the frame store
// is not cleared (only written entries are used).
// ----------------------------------------------------------------------------
module header_length_checksum_deframer_top
  import hlcd_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic        req_type,
  input  logic [7:0]  rx_byte,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status,
  output logic [7:0]  data_byte,
  output logic [5:0]  byte_index,
  output logic        last,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic          accept;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  logic          busy;
  logic          frame_done;
  cmd_t          cmd;
  cmd_t          head;
  logic [6:0]    buffer_length;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign pready = 1'b1;
  assign full   = q_full || busy;
  assign accept = push && !full;
  assign prdata = (paddr[2] == 1'b0) ? {25'd0, buffer_length} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_length <= BUF_LEN_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      buffer_length <= pwdata[6:0];
    end
  end

  hlcd_front #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .req_type     (req_type),
    .rx_byte      (rx_byte),
    .buffer_length(buffer_length),
    .frame_done   (frame_done),
    .cmd          (cmd),
    .busy         (busy),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata)
  );

  hlcd_cmd_fifo #(
    .DEPTH(CMD_DEPTH_DEF)
  ) u_cmd_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (accept),
    .wr_cmd (cmd),
    .rd_en  (q_pop),
    .rd_cmd (head),
    .q_full (q_full),
    .q_empty(q_empty)
  );

  hlcd_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_frame_store (
    .clk  (clk),
    .we   (ram_we && accept),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  hlcd_back #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .frame_done(frame_done),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .pop       (pop),
    .empty     (empty),
    .status    (status),
    .data_byte (data_byte),
    .byte_index(byte_index),
    .last      (last)
  );

endmodule
